FILE: rtl/mep_pkg.sv
// shared types, constants and colour table for the escape-time pixel block
`default_nettype none
package mep_pkg;

	localparam int MAX_ITER   = 90;
	localparam int IMAGE_SIZE = 1024;
	localparam int FRAC_BITS  = 28;

	// iteration counter holds 0 .. MAX_ITER
	localparam int CNT_W   = $clog2(MAX_ITER + 1);
	localparam int COUNT_W = 7;
	localparam int PIX_W   = $clog2(IMAGE_SIZE);
	localparam int STEP_W  = 31;
	localparam int COORD_W = 32;
	localparam int PROD_W  = PIX_W + STEP_W;
	localparam int SAT_W   = PROD_W + 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_STEP = 2'd2;

	localparam logic signed [COORD_W-1:0] ORIGIN_X_RST   = -32'sd536870912;
	localparam logic signed [COORD_W-1:0] ORIGIN_Y_RST   = -32'sd402653184;
	localparam logic [STEP_W-1:0]         PIXEL_STEP_RST = 31'd786432;

	// escape when re^2 + im^2 > 4 in q8.56
	localparam logic [63:0] ESCAPE_LIMIT = 64'd4 << (2 * FRAC_BITS);

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	typedef struct packed {
		logic signed [COORD_W-1:0] cre;
		logic signed [COORD_W-1:0] cim;
	} point_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef rgb_t [MAX_ITER-1:0] colour_rom_t;

	localparam longint ITER_SQ = longint'(MAX_ITER) * longint'(MAX_ITER);

	// clamp a wide signed value to the signed 32-bit range
	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
		logic hi_ok;
		hi_ok = (v[SAT_W-1:COORD_W-1] == {(SAT_W-COORD_W+1){v[SAT_W-1]}});
		if (hi_ok)
			return v[COORD_W-1:0];
		else if (v[SAT_W-1])
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	// truncating quotient of non-negative table constants, compare and subtract
	function automatic logic [63:0] quot_const(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [63:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// colour per count: red 255-1000(l-0.5)^2, green 1240l^3-1000l^4, blue 255l
	function automatic colour_rom_t build_colour_rom();
		colour_rom_t rom;
		longint a;
		longint d;
		logic [63:0] r;
		logic [63:0] g;
		logic [63:0] b;
		for (int n = 1; n <= MAX_ITER; n++) begin
			a = longint'(MAX_ITER - n);
			d = longint'(MAX_ITER - 2 * n);
			r = quot_const($unsigned(255 * ITER_SQ - 250 * d * d), $unsigned(ITER_SQ));
			g = quot_const($unsigned(a * a * a * (1240 * longint'(MAX_ITER) - 1000 * a)),
				$unsigned(ITER_SQ * ITER_SQ));
			b = quot_const($unsigned(255 * a), $unsigned(longint'(MAX_ITER)));
			rom[n-1].red   = r[7:0];
			rom[n-1].green = g[7:0];
			rom[n-1].blue  = b[7:0];
		end
		return rom;
	endfunction

	localparam colour_rom_t COLOUR_ROM = build_colour_rom();

endpackage
`default_nettype wire

FILE: rtl/mandelbrot_escape_pixel.sv
// escape-time pixel: front stages s1 (product) and s2 (sum and saturate), then the queue, then
// the single iteration datapath that does one complex squaring per cycle and takes a new point
// only once the last result has been loaded into its result register
// front end and queue keep taking pixels while the iteration engine is busy, until the queue is full
// reset (arst_n low, asynchronous) empties the pipeline and queue, drops any pending
// result and returns origin_x, origin_y and pixel_step to their default view
`default_nettype none
module mandelbrot_escape_pixel (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// pixel transfers in
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [mep_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // pixel_x, pixel_y, zero pad
	// result transfers out
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [mep_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // escape_count, red, green, blue, pad
	// register writes
	input  wire logic                             cfg_we,
	input  wire logic [mep_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [mep_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import mep_pkg::*;

	logic signed [COORD_W-1:0] origin_x_q;
	logic signed [COORD_W-1:0] origin_y_q;
	logic [STEP_W-1:0]         pixel_step_q;

	logic   push_valid;
	logic   push_ready;
	point_t push_data;
	logic   pop_valid;
	logic   pop_ready;
	point_t pop_data;

	logic [COUNT_W-1:0] escape_count;
	rgb_t               colour;

	// register file, writes to unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= ORIGIN_X_RST;
			origin_y_q   <= ORIGIN_Y_RST;
			pixel_step_q <= PIXEL_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ORIGIN_X:   origin_x_q   <= cfg_wdata;
				REG_ORIGIN_Y:   origin_y_q   <= cfg_wdata;
				REG_PIXEL_STEP: pixel_step_q <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// front end: multiply by step, add origin, saturate
	mep_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.pixel_x    (s_axis_tdata[PIX_W-1:0]),
		.pixel_y    (s_axis_tdata[2*PIX_W-1:PIX_W]),
		.origin_x   (origin_x_q),
		.origin_y   (origin_y_q),
		.pixel_step (pixel_step_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decoupling queue of prepared points
	mep_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// iteration engine with its own result register
	mep_iter u_iter (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.escape_count (escape_count),
		.colour       (colour)
	);

	assign m_axis_tdata = {1'b0, colour.blue, colour.green, colour.red, escape_count};

endmodule
`default_nettype wire

FILE: rtl/mep_front.sv
// front end: takes pixel transfers and forms the complex point c
`default_nettype none
module mep_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [mep_pkg::PIX_W-1:0]          pixel_x,
	input  wire logic [mep_pkg::PIX_W-1:0]          pixel_y,
	input  wire logic signed [mep_pkg::COORD_W-1:0] origin_x,
	input  wire logic signed [mep_pkg::COORD_W-1:0] origin_y,
	input  wire logic [mep_pkg::STEP_W-1:0]         pixel_step,
	output logic                                    push_valid,
	input  wire logic                               push_ready,
	output mep_pkg::point_t                         push_data
);
	import mep_pkg::*;

	logic              valid_s1;
	logic              valid_s2;
	logic [PROD_W-1:0] prod_x_s1;
	logic [PROD_W-1:0] prod_y_s1;
	point_t            point_s2;
	logic              advance;
	logic signed [SAT_W-1:0] sum_x;
	logic signed [SAT_W-1:0] sum_y;

	assign advance  = !valid_s2 || push_ready;
	assign in_ready = advance;

	// origin plus scaled offset, products are non-negative
	assign sum_x = SAT_W'(origin_x) + SAT_W'($signed({1'b0, prod_x_s1}));
	assign sum_y = SAT_W'(origin_y) + SAT_W'($signed({1'b0, prod_y_s1}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_x_s1     <= PROD_W'(pixel_x) * PROD_W'(pixel_step);
			prod_y_s1     <= PROD_W'(pixel_y) * PROD_W'(pixel_step);
			point_s2.cre  <= sat32(sum_x);
			point_s2.cim  <= sat32(sum_y);
		end
	end

	assign push_valid = valid_s2;
	assign push_data  = point_s2;

endmodule
`default_nettype wire

FILE: rtl/mep_fifo.sv
// short queue of points between front end and iteration engine
`default_nettype none
module mep_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire mep_pkg::point_t push_data,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output mep_pkg::point_t      pop_data
);
	import mep_pkg::*;

	point_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (fill_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

FILE: rtl/mep_iter.sv
// back end: escape-time iteration, colour lookup and result register
`default_nettype none
module mep_iter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pop_valid,
	output logic                               pop_ready,
	input  wire mep_pkg::point_t               pop_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mep_pkg::COUNT_W-1:0]        escape_count,
	output mep_pkg::rgb_t                      colour
);
	import mep_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t                    state_q;
	logic signed [COORD_W-1:0] zr_q;
	logic signed [COORD_W-1:0] zi_q;
	logic signed [COORD_W-1:0] cre_q;
	logic signed [COORD_W-1:0] cim_q;
	logic [CNT_W-1:0]          iter_q;
	logic                      out_valid_q;
	logic [COUNT_W-1:0]        count_q;
	rgb_t                      colour_q;

	logic signed [63:0]        rr;
	logic signed [63:0]        ii;
	logic signed [63:0]        ri;
	logic signed [63:0]        diff;
	logic [63:0]               mag;
	logic signed [SAT_W-1:0]   re_sum;
	logic signed [SAT_W-1:0]   im_sum;
	logic                      finish;
	logic                      slot_free;
	logic                      load_out;
	logic [CNT_W-1:0]          rom_idx;

	// squares of the current iterate serve both the escape test and the next step
	assign rr   = zr_q * zr_q;
	assign ii   = zi_q * zi_q;
	assign ri   = zr_q * zi_q;
	assign diff = rr - ii;
	assign mag  = $unsigned(rr) + $unsigned(ii);

	assign re_sum = SAT_W'(diff >>> FRAC_BITS) + SAT_W'(cre_q);
	assign im_sum = SAT_W'(ri >>> (FRAC_BITS - 1)) + SAT_W'(cim_q);

	assign finish    = (mag > ESCAPE_LIMIT) || (iter_q == CNT_W'(MAX_ITER));
	assign slot_free = !out_valid_q || out_ready;
	assign load_out  = slot_free && (((state_q == ST_RUN) && finish) || (state_q == ST_HOLD));
	assign rom_idx   = iter_q - 1'b1;
	assign pop_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			iter_q      <= '0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						cre_q   <= pop_data.cre;
						cim_q   <= pop_data.cim;
						zr_q    <= '0;
						zi_q    <= '0;
						iter_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (finish) begin
						if (slot_free) begin
							count_q     <= COUNT_W'(iter_q);
							colour_q    <= COLOUR_ROM[rom_idx];
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_HOLD;
						end
					end else begin
						zr_q   <= sat32(re_sum);
						zi_q   <= sat32(im_sum);
						iter_q <= iter_q + 1'b1;
					end
				end
				ST_HOLD: begin
					if (slot_free) begin
						count_q     <= COUNT_W'(iter_q);
						colour_q    <= COLOUR_ROM[rom_idx];
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign escape_count = count_q;
	assign colour       = colour_q;

endmodule
`default_nettype wire
